[design/awbg_pkg.sv]
// shared constants, register codes and types of the waveform burst generator
// no dependencies
package awbg_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
   localparam int SAMPLE_W    = 16;
   localparam int PHASE_W     = 32;
   localparam int POINT_W     = 24;
   localparam int REPS_W      = 16;
   localparam int GAIN_W      = 16;
   localparam int OPCODE_W    = 2;
   localparam int ADDR_W      = 10;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int FRAC_W      = GAIN_W - 1;
   localparam int PROD_W      = SAMPLE_W + GAIN_W + 1;
   localparam int SCALED_W    = PROD_W - FRAC_W;
   localparam int SUM_W       = SCALED_W + 1;

   localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_START = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_PHASE_STEP    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BURST_POINTS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD_POINTS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BURST_REPS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_AMP_GAIN      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LEVEL_OFFSET  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_INIT_LEVEL    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_IDLE_LEVEL    = 3'd7;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase_step;
      logic [POINT_W-1:0] burst_points;
      logic [POINT_W-1:0] period_points;
      logic [REPS_W-1:0]  burst_reps;
      logic [GAIN_W-1:0]  amplitude_gain;
      sample_type         level_offset;
      sample_type         init_level;
      sample_type         idle_level;
   } cfg_type;

   typedef struct packed {
      logic       burst;
      logic       done;
      sample_type level;
   } point_type;

endpackage

[design/awbg_req_if.sv]
// request channel of the waveform burst generator: valid, ready and payload
// depends on awbg_pkg
interface awbg_req_if;
   logic                              valid;
   logic                              ready;
   logic [awbg_pkg::OPCODE_W-1:0]     opcode;
   logic [awbg_pkg::ADDR_W-1:0]       table_address;
   logic signed [awbg_pkg::SAMPLE_W-1:0] table_value;

   modport source (output valid, output opcode, output table_address, output table_value,
                   input ready);
   modport sink (input valid, input opcode, input table_address, input table_value,
                 output ready);
endinterface

[design/awbg_rsp_if.sv]
// result channel of the waveform burst generator: valid, ready and payload
// depends on awbg_pkg
interface awbg_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [awbg_pkg::SAMPLE_W-1:0] sample;
   logic                                 in_burst;
   logic                                 sequence_done;

   modport source (output valid, output sample, output in_burst, output sequence_done,
                   input ready);
   modport sink (input valid, input sample, input in_burst, input sequence_done,
                 output ready);
endinterface

[design/awbg_csr.sv]
// configuration registers of the waveform burst generator
// depends on awbg_pkg
module awbg_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [awbg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [awbg_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output awbg_pkg::cfg_type                   cfg
);
   import awbg_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_step     <= '0;
         cfg_ff.burst_points   <= '0;
         cfg_ff.period_points  <= '0;
         cfg_ff.burst_reps     <= REPS_W'(1);
         cfg_ff.amplitude_gain <= GAIN_W'(32768);
         cfg_ff.level_offset   <= '0;
         cfg_ff.init_level     <= '0;
         cfg_ff.idle_level     <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_PHASE_STEP:    cfg_ff.phase_step     <= csr_wdata[PHASE_W-1:0];
            REG_BURST_POINTS:  cfg_ff.burst_points   <= csr_wdata[POINT_W-1:0];
            REG_PERIOD_POINTS: cfg_ff.period_points  <= csr_wdata[POINT_W-1:0];
            REG_BURST_REPS:    cfg_ff.burst_reps     <= csr_wdata[REPS_W-1:0];
            REG_AMP_GAIN:      cfg_ff.amplitude_gain <= csr_wdata[GAIN_W-1:0];
            REG_LEVEL_OFFSET:  cfg_ff.level_offset   <= csr_wdata[SAMPLE_W-1:0];
            REG_INIT_LEVEL:    cfg_ff.init_level     <= csr_wdata[SAMPLE_W-1:0];
            REG_IDLE_LEVEL:    cfg_ff.idle_level     <= csr_wdata[SAMPLE_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

[design/awbg_table.sv]
// waveform sample memory, one write port and one registered read port
// depends on awbg_pkg
module awbg_table (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [awbg_pkg::TABLE_AW-1:0]    wr_addr,
   input  awbg_pkg::sample_type             wr_data,
   input  logic                             rd_en,
   input  logic [awbg_pkg::TABLE_AW-1:0]    rd_addr,
   output awbg_pkg::sample_type             rd_data
);
   import awbg_pkg::*;

   sample_type mem [TABLE_DEPTH];
   sample_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/awbg_seq.sv]
// burst sequencer: phase accumulator, point and repetition counters
// depends on awbg_pkg
module awbg_seq (
   input  logic                             clock,
   input  logic                             reset,
   input  awbg_pkg::cfg_type                cfg,
   input  logic                             accept,
   input  logic [awbg_pkg::OPCODE_W-1:0]    opcode,
   output logic [awbg_pkg::TABLE_AW-1:0]    rd_addr,
   output awbg_pkg::point_type              point
);
   import awbg_pkg::*;

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [POINT_W-1:0] count_ff, count_in;
   logic [REPS_W-1:0]  reps_ff, reps_in;
   logic               started_ff, started_in;

   logic [POINT_W-1:0] period;
   logic [POINT_W:0]   count_inc;
   logic               wrap;
   logic               in_table;
   logic               running;

   always_comb begin
      period    = (cfg.period_points > cfg.burst_points) ? cfg.period_points
                                                         : cfg.burst_points;
      count_inc = {1'b0, count_ff} + (POINT_W+1)'(1);
      wrap      = count_inc >= {1'b0, period};
      in_table  = count_ff < cfg.burst_points;
      running   = started_ff && (reps_ff < cfg.burst_reps);

      point.burst = running && in_table;
      point.done  = started_ff && !running;
      point.level = started_ff ? cfg.idle_level : cfg.init_level;
      rd_addr     = phase_ff[PHASE_W-1 -: TABLE_AW];

      phase_in   = phase_ff;
      count_in   = count_ff;
      reps_in    = reps_ff;
      started_in = started_ff;
      if (accept) begin
         if (opcode == OP_START) begin
            phase_in   = '0;
            count_in   = '0;
            reps_in    = '0;
            started_in = 1'b1;
         end else if (opcode == OP_TICK && running) begin
            if (in_table) begin
               phase_in = phase_ff + cfg.phase_step;
            end
            count_in = count_inc[POINT_W-1:0];
            if (wrap) begin
               count_in = '0;
               phase_in = '0;
               reps_in  = reps_ff + REPS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         count_ff   <= '0;
         reps_ff    <= '0;
         started_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         reps_ff    <= reps_in;
         started_ff <= started_in;
      end
   end

endmodule

[design/awbg_scale.sv]
// point pipeline: gain multiply, rounding, offset, saturation, result register
// depends on awbg_pkg
module awbg_scale (
   input  logic                 clock,
   input  logic                 reset,
   input  awbg_pkg::cfg_type    cfg,
   input  logic                 tick_accept,
   input  awbg_pkg::point_type  point,
   input  awbg_pkg::sample_type table_data,
   output logic                 s1_ready,
   output logic                 out_valid,
   input  logic                 out_ready,
   output awbg_pkg::sample_type out_sample,
   output logic                 out_burst,
   output logic                 out_done
);
   import awbg_pkg::*;

   localparam logic signed [SUM_W-1:0] SAT_HI =
      {{(SUM_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_W - 1);

   logic                     s1_valid_ff, s2_valid_ff, out_valid_ff;
   point_type                s1_ff, s2_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   sample_type               sample_ff, sample_in;
   logic                     burst_ff, done_ff;

   logic                     s2_ready, o_ready;
   logic signed [PROD_W-1:0] rounded;
   logic signed [SUM_W-1:0]  sum;

   always_comb begin
      o_ready  = !out_valid_ff || out_ready;
      s2_ready = !s2_valid_ff || o_ready;
      s1_ready = !s1_valid_ff || s2_ready;

      prod_in = PROD_W'($signed(table_data)) * PROD_W'($signed({1'b0, cfg.amplitude_gain}));

      rounded = prod_ff + ROUND_HALF;
      sum     = SUM_W'($signed(rounded[PROD_W-1:FRAC_W])) + SUM_W'(cfg.level_offset);
      priority if (!s2_ff.burst) begin
         sample_in = s2_ff.level;
      end else if (sum > SAT_HI) begin
         sample_in = SAT_HI[SAMPLE_W-1:0];
      end else if (sum < SAT_LO) begin
         sample_in = SAT_LO[SAMPLE_W-1:0];
      end else begin
         sample_in = sum[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= tick_accept;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (o_ready)  out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_ff <= point;
      end
      if (s2_ready) begin
         s2_ff   <= s1_ff;
         prod_ff <= prod_in;
      end
      if (o_ready) begin
         sample_ff <= sample_in;
         burst_ff  <= s2_ff.burst;
         done_ff   <= s2_ff.done;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_sample = sample_ff;
   assign out_burst  = burst_ff;
   assign out_done   = done_ff;

endmodule

[design/arbitrary_waveform_burst_gen_top.sv]
// top level of the arbitrary waveform burst generator
// depends on awbg_pkg, awbg_req_if, awbg_rsp_if, awbg_csr, awbg_seq, awbg_table, awbg_scale
//
// req_bus carries one beat per command: load a table word, tick one output point,
// or start a burst sequence. only ticks produce a beat on rsp_bus, carrying the
// sample, an in_burst flag and a sequence_done flag. csr_we/csr_index/csr_wdata write
// the eight setup registers; the user must do this only while the block is idle, as the
// block does not enforce it. a tick reaches rsp_bus through the table read register, which
// loads with the beat, then the gain multiply register, then the result register after
// rounding, offset and saturation; a stall on rsp_bus can hold it in any of them.
// a beat is taken every cycle while req ready holds; sequencer state updates in that cycle.
// every stage has its own valid bit, so req_bus stays ready while empty stages
// remain in front of a stalled result; a full pipeline holds and drops req ready.
// reset clears the sequencer, pipeline valid bits and registers to their defaults;
// the sample table is not cleared and must be loaded before use.
module arbitrary_waveform_burst_gen_top (
   input  logic                             clock,
   input  logic                             reset,
   awbg_req_if.sink                         req_bus,
   awbg_rsp_if.source                       rsp_bus,
   input  logic                             csr_we,
   input  logic [awbg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [awbg_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import awbg_pkg::*;

   cfg_type               cfg;
   point_type             point;
   logic                  s1_ready;
   logic                  accept;
   logic                  tick_accept;
   logic                  load_accept;
   logic [TABLE_AW-1:0]   rd_addr;
   sample_type            table_data;

   assign req_bus.ready = s1_ready;
   assign accept        = req_bus.valid && s1_ready;
   assign tick_accept   = accept && (req_bus.opcode == OP_TICK);
   assign load_accept   = accept && (req_bus.opcode == OP_LOAD);

   awbg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   awbg_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .accept  (accept),
      .opcode  (req_bus.opcode),
      .rd_addr (rd_addr),
      .point   (point)
   );

   awbg_table u_table (
      .clock   (clock),
      .wr_en   (load_accept),
      .wr_addr (req_bus.table_address[TABLE_AW-1:0]),
      .wr_data (req_bus.table_value),
      .rd_en   (tick_accept),
      .rd_addr (rd_addr),
      .rd_data (table_data)
   );

   awbg_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .tick_accept (tick_accept),
      .point       (point),
      .table_data  (table_data),
      .s1_ready    (s1_ready),
      .out_valid   (rsp_bus.valid),
      .out_ready   (rsp_bus.ready),
      .out_sample  (rsp_bus.sample),
      .out_burst   (rsp_bus.in_burst),
      .out_done    (rsp_bus.sequence_done)
   );

endmodule
